@@ rtl/tbc_pkg.sv @@
// ----------------------------------------------------------------------------
// tbc_pkg
// Shared widths, codes, queue entry type and helpers for the tile/box
// collision block.
// ----------------------------------------------------------------------------
package tbc_pkg;

  // Coordinate format: Q12.4 signed positions, unsigned sizes one bit narrower
  localparam int COORD_BITS   = 16;
  localparam int SIZE_BITS    = COORD_BITS - 1;
  localparam int CONTACT_BITS = COORD_BITS + 1;
  localparam int DEPTH_BITS   = 22;
  // Internal Q.5 math width, roomy enough for every sum and its negation
  localparam int WIDE_BITS    = COORD_BITS + 6;
  localparam int SAT_BITS     = (WIDE_BITS > DEPTH_BITS) ? WIDE_BITS : DEPTH_BITS;

  // Queue between front and back
  localparam int Q_DEPTH      = 2;
  localparam int Q_PTR_BITS   = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS   = $clog2(Q_DEPTH + 1);

  // Tile kinds
  localparam logic [1:0] KIND_SOLID     = 2'd0;
  localparam logic [1:0] KIND_RAMP_UP   = 2'd1;
  localparam logic [1:0] KIND_RAMP_DOWN = 2'd2;

  // Classification made by the front
  localparam logic [1:0] CLS_MISS  = 2'd0;
  localparam logic [1:0] CLS_SOLID = 2'd1;
  localparam logic [1:0] CLS_RAMP  = 2'd2;

  // Normal component codes
  localparam logic signed [1:0] NORM_ZERO = 2'sb00;
  localparam logic signed [1:0] NORM_POS  = 2'sb01;
  localparam logic signed [1:0] NORM_NEG  = 2'sb11;

  localparam logic signed [SAT_BITS-1:0] DEPTH_HI =
    {{(SAT_BITS - DEPTH_BITS + 1){1'b0}}, {(DEPTH_BITS - 1){1'b1}}};
  localparam logic signed [SAT_BITS-1:0] DEPTH_LO = ~DEPTH_HI;

  typedef struct packed {
    logic [1:0]                   cls;
    logic                         down;      // ramp down: mirror x
    logic                         grounded;
    logic signed [COORD_BITS-1:0] tx;
    logic signed [COORD_BITS-1:0] ty;
    logic [SIZE_BITS-1:0]         tw;
    logic [SIZE_BITS-1:0]         th;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
    logic [SIZE_BITS-1:0]         bw;
    logic [SIZE_BITS-1:0]         bh;
    logic signed [WIDE_BITS-1:0]  xov;       // Q.5 overlaps
    logic signed [WIDE_BITS-1:0]  yov;
    logic signed [WIDE_BITS-1:0]  cx2;       // 2*box_x + box_w
  } tbc_entry_t;

  function automatic logic signed [WIDE_BITS-1:0] pos_ext(
    input logic signed [COORD_BITS-1:0] v);
    pos_ext = WIDE_BITS'(v);
  endfunction

  function automatic logic signed [WIDE_BITS-1:0] size_ext(
    input logic [SIZE_BITS-1:0] v);
    size_ext = signed'(WIDE_BITS'(v));
  endfunction

  function automatic logic signed [DEPTH_BITS-1:0] sat_depth(
    input logic signed [WIDE_BITS-1:0] v);
    logic signed [SAT_BITS-1:0] vx;
    logic signed [SAT_BITS-1:0] r;
    vx = SAT_BITS'(v);
    if (vx > DEPTH_HI) begin
      r = DEPTH_HI;
    end else if (vx < DEPTH_LO) begin
      r = DEPTH_LO;
    end else begin
      r = vx;
    end
    sat_depth = r[DEPTH_BITS-1:0];
  endfunction

endpackage

@@ rtl/tbc_front.sv @@
// ----------------------------------------------------------------------------
// tbc_front
// Overlap test and classification of one incoming tile/box word.
// ----------------------------------------------------------------------------
module tbc_front (
  input  logic [1:0]                            tile_kind,
  input  logic signed [tbc_pkg::COORD_BITS-1:0] tile_x,
  input  logic signed [tbc_pkg::COORD_BITS-1:0] tile_y,
  input  logic [tbc_pkg::SIZE_BITS-1:0]         tile_w,
  input  logic [tbc_pkg::SIZE_BITS-1:0]         tile_h,
  input  logic signed [tbc_pkg::COORD_BITS-1:0] box_x,
  input  logic signed [tbc_pkg::COORD_BITS-1:0] box_y,
  input  logic [tbc_pkg::SIZE_BITS-1:0]         box_w,
  input  logic [tbc_pkg::SIZE_BITS-1:0]         box_h,
  input  logic                                  grounded,
  output tbc_pkg::tbc_entry_t                   entry
);

  logic signed [tbc_pkg::WIDE_BITS-1:0] tx_s, ty_s, tw_s, th_s;
  logic signed [tbc_pkg::WIDE_BITS-1:0] bx_s, by_s, bw_s, bh_s;
  logic signed [tbc_pkg::WIDE_BITS-1:0] cx2, cy2, dx, dy, adx, ady, xov, yov;
  logic                                 miss, is_ramp, in_span;

  assign tx_s = tbc_pkg::pos_ext(tile_x);
  assign ty_s = tbc_pkg::pos_ext(tile_y);
  assign tw_s = tbc_pkg::size_ext(tile_w);
  assign th_s = tbc_pkg::size_ext(tile_h);
  assign bx_s = tbc_pkg::pos_ext(box_x);
  assign by_s = tbc_pkg::pos_ext(box_y);
  assign bw_s = tbc_pkg::size_ext(box_w);
  assign bh_s = tbc_pkg::size_ext(box_h);

  // center distances in Q.5
  assign cx2 = (bx_s <<< 1) + bw_s;
  assign cy2 = (by_s <<< 1) + bh_s;
  assign dx  = cx2 - ((tx_s <<< 1) + tw_s);
  assign dy  = cy2 - ((ty_s <<< 1) + th_s);
  assign adx = dx[tbc_pkg::WIDE_BITS-1] ? -dx : dx;
  assign ady = dy[tbc_pkg::WIDE_BITS-1] ? -dy : dy;
  assign xov = tw_s + bw_s - adx;
  assign yov = th_s + bh_s - ady;

  assign miss    = xov[tbc_pkg::WIDE_BITS-1] || (xov == '0) ||
                   yov[tbc_pkg::WIDE_BITS-1] || (yov == '0);
  assign is_ramp = (tile_kind == tbc_pkg::KIND_RAMP_UP) ||
                   (tile_kind == tbc_pkg::KIND_RAMP_DOWN);
  // bottom center strictly within the tile's x span
  assign in_span = (cx2 > (tx_s <<< 1)) && (cx2 < ((tx_s + tw_s) <<< 1));

  always_comb begin
    entry.tx       = tile_x;
    entry.ty       = tile_y;
    entry.tw       = tile_w;
    entry.th       = tile_h;
    entry.bx       = box_x;
    entry.by       = box_y;
    entry.bw       = box_w;
    entry.bh       = box_h;
    entry.grounded = grounded;
    entry.down     = (tile_kind == tbc_pkg::KIND_RAMP_DOWN);
    entry.xov      = xov;
    entry.yov      = yov;
    entry.cx2      = cx2;
    if (miss || (is_ramp && !in_span)) begin
      entry.cls = tbc_pkg::CLS_MISS;
    end else if (is_ramp) begin
      entry.cls = tbc_pkg::CLS_RAMP;
    end else begin
      entry.cls = tbc_pkg::CLS_SOLID;
    end
  end

endmodule

@@ rtl/tbc_queue.sv @@
// ----------------------------------------------------------------------------
// tbc_queue
// Short FIFO of classified words between the front and the back.
// ----------------------------------------------------------------------------
module tbc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tbc_pkg::tbc_entry_t push_entry,
  input  logic                pop,
  output tbc_pkg::tbc_entry_t head,
  output logic                full,
  output logic                empty
);

  localparam logic [tbc_pkg::Q_PTR_BITS-1:0] PTR_LAST =
    tbc_pkg::Q_PTR_BITS'(tbc_pkg::Q_DEPTH - 1);
  localparam logic [tbc_pkg::Q_CNT_BITS-1:0] CNT_FULL =
    tbc_pkg::Q_CNT_BITS'(tbc_pkg::Q_DEPTH);

  tbc_pkg::tbc_entry_t                 mem_r [tbc_pkg::Q_DEPTH];
  logic [tbc_pkg::Q_PTR_BITS-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [tbc_pkg::Q_PTR_BITS-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [tbc_pkg::Q_CNT_BITS-1:0]      count_r, count_nxt;

  assign full  = (count_r == CNT_FULL);
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

@@ rtl/tbc_back.sv @@
// ----------------------------------------------------------------------------
// tbc_back
// Resolves a classified word into normal, depth and contact and holds the
// result in the output register.
// ----------------------------------------------------------------------------
module tbc_back (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  tbc_pkg::tbc_entry_t                     head,
  input  logic                                    empty,
  output logic                                    pop,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic                                    out_hit,
  output logic signed [tbc_pkg::CONTACT_BITS-1:0] out_contact_x,
  output logic signed [tbc_pkg::CONTACT_BITS-1:0] out_contact_y,
  output logic signed [1:0]                       out_normal_x,
  output logic signed [1:0]                       out_normal_y,
  output logic signed [tbc_pkg::DEPTH_BITS-1:0]   out_depth
);

  logic signed [tbc_pkg::WIDE_BITS-1:0] tx, ty, tw, th, bx, by, bw, bh;
  logic signed [tbc_pkg::WIDE_BITS-1:0] cx2m, bottom, dist2, cx_sel, cy_sel, d_sel;
  logic signed [tbc_pkg::WIDE_BITS-1:0] t_right, t_bot, b_right, b_bot;
  logic                                 drop;
  logic                                 hit_nxt;
  logic signed [1:0]                    nx_nxt, ny_nxt;

  logic                                 valid_r;
  logic                                 hit_r;
  logic signed [tbc_pkg::CONTACT_BITS-1:0] cx_r, cy_r;
  logic signed [1:0]                    nx_r, ny_r;
  logic signed [tbc_pkg::DEPTH_BITS-1:0] depth_r, depth_nxt;

  assign tx = tbc_pkg::pos_ext(head.tx);
  assign ty = tbc_pkg::pos_ext(head.ty);
  assign tw = tbc_pkg::size_ext(head.tw);
  assign th = tbc_pkg::size_ext(head.th);
  assign bx = tbc_pkg::pos_ext(head.bx);
  assign by = tbc_pkg::pos_ext(head.by);
  assign bw = tbc_pkg::size_ext(head.bw);
  assign bh = tbc_pkg::size_ext(head.bh);

  assign t_right = tx + tw;
  assign t_bot   = ty + th;
  assign b_right = bx + bw;
  assign b_bot   = by + bh;

  // ramp: mirrored bottom center, distance of the box bottom above the slope
  assign bottom = b_bot;
  assign cx2m   = head.down ? ((tx <<< 2) + (tw <<< 1) - head.cx2) : head.cx2;
  assign dist2  = (t_bot <<< 1) - (cx2m - (tx <<< 1)) - (bottom <<< 1);
  assign drop   = !head.grounded && !dist2[tbc_pkg::WIDE_BITS-1] && (dist2 != '0);

  always_comb begin
    hit_nxt = 1'b0;
    cx_sel  = '0;
    cy_sel  = '0;
    d_sel   = '0;
    nx_nxt  = tbc_pkg::NORM_ZERO;
    ny_nxt  = tbc_pkg::NORM_ZERO;
    case (head.cls)
      tbc_pkg::CLS_RAMP: begin
        if (!drop) begin
          hit_nxt = 1'b1;
          cx_sel  = cx2m >>> 1;  // floor to Q12.4
          cy_sel  = bottom;
          ny_nxt  = tbc_pkg::NORM_NEG;
          d_sel   = -dist2;
        end
      end
      tbc_pkg::CLS_SOLID: begin
        hit_nxt = 1'b1;
        if (head.xov < head.yov) begin
          cx_sel = (tx > bx) ? tx : bx;
          cy_sel = (ty > by) ? ty : by;
          nx_nxt = (bx < tx) ? tbc_pkg::NORM_NEG : tbc_pkg::NORM_POS;
          d_sel  = head.xov;
        end else begin
          // ties go to the y axis
          cx_sel = (t_right < b_right) ? t_right : b_right;
          cy_sel = (t_bot < b_bot) ? t_bot : b_bot;
          ny_nxt = (by < ty) ? tbc_pkg::NORM_NEG : tbc_pkg::NORM_POS;
          d_sel  = head.yov;
        end
      end
      default: begin
        hit_nxt = 1'b0;
      end
    endcase
    depth_nxt = tbc_pkg::sat_depth(d_sel);
  end

  assign pop = !empty && (!valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      hit_r   <= hit_nxt;
      cx_r    <= cx_sel[tbc_pkg::CONTACT_BITS-1:0];
      cy_r    <= cy_sel[tbc_pkg::CONTACT_BITS-1:0];
      nx_r    <= nx_nxt;
      ny_r    <= ny_nxt;
      depth_r <= depth_nxt;
    end
  end

  assign out_valid     = valid_r;
  assign out_hit       = hit_r;
  assign out_contact_x = cx_r;
  assign out_contact_y = cy_r;
  assign out_normal_x  = nx_r;
  assign out_normal_y  = ny_r;
  assign out_depth     = depth_r;

endmodule

@@ rtl/tile_box_collision.sv @@
// ----------------------------------------------------------------------------
// tile_box_collision
// Streaming collision test of one tile rectangle against one hitbox per word.
// ----------------------------------------------------------------------------
// Each input word carries a tile (solid, ramp up or ramp down), a hitbox and
// a grounded flag, all in Q12.4; each produces exactly one result word with
// hit, contact point, unit normal and a saturated Q.5 penetration depth (all
// zero on a miss). Throughput is one word per clock in steady state while
// out_stall is low. The word is classified on the way into a two-entry
// queue and resolved on the way out of it into the output register.
// in_stall rises only when the queue holds two words, which happens once
// the result side has stalled long enough to back it up.
// No configuration and no state is kept between words.
// ----------------------------------------------------------------------------
module tile_box_collision (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // input channel
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [1:0]                              in_tile_kind,
  input  logic signed [tbc_pkg::COORD_BITS-1:0]   in_tile_x,
  input  logic signed [tbc_pkg::COORD_BITS-1:0]   in_tile_y,
  input  logic [tbc_pkg::SIZE_BITS-1:0]           in_tile_w,
  input  logic [tbc_pkg::SIZE_BITS-1:0]           in_tile_h,
  input  logic signed [tbc_pkg::COORD_BITS-1:0]   in_box_x,
  input  logic signed [tbc_pkg::COORD_BITS-1:0]   in_box_y,
  input  logic [tbc_pkg::SIZE_BITS-1:0]           in_box_w,
  input  logic [tbc_pkg::SIZE_BITS-1:0]           in_box_h,
  input  logic                                    in_grounded,
  // result channel
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic                                    out_hit,
  output logic signed [tbc_pkg::CONTACT_BITS-1:0] out_contact_x,
  output logic signed [tbc_pkg::CONTACT_BITS-1:0] out_contact_y,
  output logic signed [1:0]                       out_normal_x,
  output logic signed [1:0]                       out_normal_y,
  output logic signed [tbc_pkg::DEPTH_BITS-1:0]   out_depth
);

  tbc_pkg::tbc_entry_t front_entry;  // classified word from the front
  tbc_pkg::tbc_entry_t q_head;       // oldest queued word
  logic                q_full;
  logic                q_empty;
  logic                push;
  logic                pop;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // Front: overlap per axis and solid / ramp / miss decision
  tbc_front u_front (
    .tile_kind (in_tile_kind),
    .tile_x    (in_tile_x),
    .tile_y    (in_tile_y),
    .tile_w    (in_tile_w),
    .tile_h    (in_tile_h),
    .box_x     (in_box_x),
    .box_y     (in_box_y),
    .box_w     (in_box_w),
    .box_h     (in_box_h),
    .grounded  (in_grounded),
    .entry     (front_entry)
  );

  // Decoupling queue: lets the input keep flowing while a result waits
  tbc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (front_entry),
    .pop        (pop),
    .head       (q_head),
    .full       (q_full),
    .empty      (q_empty)
  );

  // Back: slope test / axis pick, saturation, output register
  tbc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (q_head),
    .empty         (q_empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hit       (out_hit),
    .out_contact_x (out_contact_x),
    .out_contact_y (out_contact_y),
    .out_normal_x  (out_normal_x),
    .out_normal_y  (out_normal_y),
    .out_depth     (out_depth)
  );

endmodule

@@ tb/tile_box_collision_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tile_box_collision_test
// Self-checking bench for the tile/hitbox collision block. Every accepted
// word is run through a local collision predictor and the expected result is
// queued; each result word is checked field by field against the oldest
// entry. A short directed set hits the edge cases, then random words, mostly
// placed near or on the tile and hugging ramp slopes, are streamed under
// several sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module tile_box_collision_test;
  import tbc_pkg::*;

  // tile_kind code that the block folds into the solid path
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam int WATCHDOG_CYCLES = 2000;  // cycles without any handshake
  localparam int DRAIN_CYCLES    = 8;     // settle time after the last result
  localparam int PHASE_WORDS     = 320;
  localparam int MAX_PRINTED     = 40;

  // One input word: tile, hitbox and grounded flag
  typedef struct packed {
    logic [1:0]                   kind;
    logic signed [COORD_BITS-1:0] tile_x;
    logic signed [COORD_BITS-1:0] tile_y;
    logic [SIZE_BITS-1:0]         tile_w;
    logic [SIZE_BITS-1:0]         tile_h;
    logic signed [COORD_BITS-1:0] box_x;
    logic signed [COORD_BITS-1:0] box_y;
    logic [SIZE_BITS-1:0]         box_w;
    logic [SIZE_BITS-1:0]         box_h;
    logic                         grounded;
  } pair_word_t;

  // One result word
  typedef struct packed {
    logic                           hit;
    logic signed [CONTACT_BITS-1:0] contact_x;
    logic signed [CONTACT_BITS-1:0] contact_y;
    logic signed [1:0]              normal_x;
    logic signed [1:0]              normal_y;
    logic signed [DEPTH_BITS-1:0]   depth;
  } collision_t;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts each accepted pair and checks results in order
  // --------------------------------------------------------------------------
  class collision_scoreboard;
    collision_t pending[$];
    int         errors;
    int         results_seen;

    function new();
      errors       = 0;
      results_seen = 0;
    endfunction

    function longint magnitude(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function logic signed [DEPTH_BITS-1:0] clamp_depth(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) << (DEPTH_BITS - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return DEPTH_BITS'(v);
    endfunction

    // Overlaps and slope distance in Q.5 (twice Q12.4), all math on 64-bit signed, so nothing wraps
    function collision_t resolve_collision(pair_word_t w);
      collision_t r;
      longint tx, ty, tw, th, bx, by, bw, bh;
      longint xov, yov, cx2, bottom, dist2;
      r  = '0;
      tx = $signed(w.tile_x);
      ty = $signed(w.tile_y);
      tw = w.tile_w;
      th = w.tile_h;
      bx = $signed(w.box_x);
      by = $signed(w.box_y);
      bw = w.box_w;
      bh = w.box_h;
      xov = tw + bw - magnitude(2 * bx + bw - 2 * tx - tw);
      yov = th + bh - magnitude(2 * by + bh - 2 * ty - th);
      if (xov <= 0 || yov <= 0) return r;

      if (w.kind == KIND_RAMP_UP || w.kind == KIND_RAMP_DOWN) begin
        cx2    = 2 * bx + bw;
        bottom = by + bh;
        // bottom centre must sit strictly inside the tile's x span
        if (cx2 <= 2 * tx || cx2 >= 2 * (tx + tw)) return r;
        if (w.kind == KIND_RAMP_DOWN) cx2 = 4 * tx + 2 * tw - cx2;
        dist2 = 2 * (ty + th) - (cx2 - 2 * tx) - 2 * bottom;
        // airborne and above the slope: no contact yet
        if (!w.grounded && dist2 > 0) return r;
        r.hit       = 1'b1;
        r.contact_x = CONTACT_BITS'(cx2 >>> 1);  // floor to Q12.4
        r.contact_y = CONTACT_BITS'(bottom);
        r.normal_x  = NORM_ZERO;
        r.normal_y  = NORM_NEG;
        r.depth     = clamp_depth(-dist2);
      end else if (xov < yov) begin
        r.hit       = 1'b1;
        r.contact_x = CONTACT_BITS'((tx > bx) ? tx : bx);
        r.contact_y = CONTACT_BITS'((ty > by) ? ty : by);
        r.normal_x  = (bx < tx) ? NORM_NEG : NORM_POS;
        r.normal_y  = NORM_ZERO;
        r.depth     = clamp_depth(xov);
      end else begin
        // ties go to the y axis
        r.hit       = 1'b1;
        r.contact_x = CONTACT_BITS'((tx + tw < bx + bw) ? tx + tw : bx + bw);
        r.contact_y = CONTACT_BITS'((ty + th < by + bh) ? ty + th : by + bh);
        r.normal_x  = NORM_ZERO;
        r.normal_y  = (by < ty) ? NORM_NEG : NORM_POS;
        r.depth     = clamp_depth(yov);
      end
      return r;
    endfunction

    function void note_input(pair_word_t w);
      pending.push_back(resolve_collision(w));
    endfunction

    task report_mismatch(string msg);
      if (errors < MAX_PRINTED) $display("MISMATCH result %0d: %s", results_seen, msg);
      errors++;
    endtask

    task check_result(collision_t got);
      collision_t want;
      if (pending.size() == 0) begin
        report_mismatch("result word with nothing pending");
        results_seen++;
        return;
      end
      want = pending.pop_front();
      if (got.hit !== want.hit)
        report_mismatch($sformatf("hit got %0d want %0d", got.hit, want.hit));
      if (got.contact_x !== want.contact_x)
        report_mismatch($sformatf("contact_x got %0d want %0d",
                                  $signed(got.contact_x), $signed(want.contact_x)));
      if (got.contact_y !== want.contact_y)
        report_mismatch($sformatf("contact_y got %0d want %0d",
                                  $signed(got.contact_y), $signed(want.contact_y)));
      if (got.normal_x !== want.normal_x)
        report_mismatch($sformatf("normal_x got %0d want %0d",
                                  $signed(got.normal_x), $signed(want.normal_x)));
      if (got.normal_y !== want.normal_y)
        report_mismatch($sformatf("normal_y got %0d want %0d",
                                  $signed(got.normal_y), $signed(want.normal_y)));
      if (got.depth !== want.depth)
        report_mismatch($sformatf("depth got %0d want %0d",
                                  $signed(got.depth), $signed(want.depth)));
      results_seen++;
    endtask
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                           in_valid     = 1'b0;
  logic                           in_stall;
  logic [1:0]                     in_tile_kind = KIND_SOLID;
  logic signed [COORD_BITS-1:0]   in_tile_x    = '0;
  logic signed [COORD_BITS-1:0]   in_tile_y    = '0;
  logic [SIZE_BITS-1:0]           in_tile_w    = '0;
  logic [SIZE_BITS-1:0]           in_tile_h    = '0;
  logic signed [COORD_BITS-1:0]   in_box_x     = '0;
  logic signed [COORD_BITS-1:0]   in_box_y     = '0;
  logic [SIZE_BITS-1:0]           in_box_w     = '0;
  logic [SIZE_BITS-1:0]           in_box_h     = '0;
  logic                           in_grounded  = 1'b0;

  logic                           out_valid;
  logic                           out_stall    = 1'b0;
  logic                           out_hit;
  logic signed [CONTACT_BITS-1:0] out_contact_x;
  logic signed [CONTACT_BITS-1:0] out_contact_y;
  logic signed [1:0]              out_normal_x;
  logic signed [1:0]              out_normal_y;
  logic signed [DEPTH_BITS-1:0]   out_depth;

  tile_box_collision dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_tile_kind  (in_tile_kind),
    .in_tile_x     (in_tile_x),
    .in_tile_y     (in_tile_y),
    .in_tile_w     (in_tile_w),
    .in_tile_h     (in_tile_h),
    .in_box_x      (in_box_x),
    .in_box_y      (in_box_y),
    .in_box_w      (in_box_w),
    .in_box_h      (in_box_h),
    .in_grounded   (in_grounded),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hit       (out_hit),
    .out_contact_x (out_contact_x),
    .out_contact_y (out_contact_y),
    .out_normal_x  (out_normal_x),
    .out_normal_y  (out_normal_y),
    .out_depth     (out_depth)
  );

  collision_scoreboard sb;

  // Idle mix of the current phase, in percent of cycles
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int quiet_cycles  = 0;

  always #1 clk = ~clk;

  // Receiver: random stall, changed only at the falling edge
  always @(negedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(1, 100) <= stall_pct);
  end

  // Result monitor and handshake watchdog, both on the rising edge
  always @(posedge clk) begin : monitor
    collision_t got;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.hit       = out_hit;
        got.contact_x = out_contact_x;
        got.contact_y = out_contact_y;
        got.normal_x  = out_normal_x;
        got.normal_y  = out_normal_y;
        got.depth     = out_depth;
        sb.check_result(got);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_CYCLES);
        $display("tile_box_collision_test: done, errors");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Present a word at the falling edge and hold it until it is taken
  task automatic drive_word(input pair_word_t w);
    @(negedge clk);
    in_valid     <= 1'b1;
    in_tile_kind <= w.kind;
    in_tile_x    <= w.tile_x;
    in_tile_y    <= w.tile_y;
    in_tile_w    <= w.tile_w;
    in_tile_h    <= w.tile_h;
    in_box_x     <= w.box_x;
    in_box_y     <= w.box_y;
    in_box_w     <= w.box_w;
    in_box_h     <= w.box_h;
    in_grounded  <= w.grounded;
    do @(posedge clk); while (in_stall);
    sb.note_input(w);
  endtask

  task automatic idle_cycle();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Directed pair; int arguments are cut down to the port widths
  task automatic send_pair(input logic [1:0] kind, input int tx, input int ty,
                           input int tw, input int th, input int bx, input int by,
                           input int bw, input int bh, input logic g);
    pair_word_t w;
    w.kind     = kind;
    w.tile_x   = COORD_BITS'(tx);
    w.tile_y   = COORD_BITS'(ty);
    w.tile_w   = SIZE_BITS'(tw);
    w.tile_h   = SIZE_BITS'(th);
    w.box_x    = COORD_BITS'(bx);
    w.box_y    = COORD_BITS'(by);
    w.box_w    = SIZE_BITS'(bw);
    w.box_h    = SIZE_BITS'(bh);
    w.grounded = g;
    drive_word(w);
  endtask

  // Mostly small sizes; a full-range size now and then
  function automatic int pick_size(int typical);
    if ($urandom_range(0, 19) == 0) return int'($urandom_range(0, 32767));
    return int'($urandom_range(1, typical));
  endfunction

  // Random pair: some fully random, the rest placed so that the rectangles
  // touch or overlap, and most ramp words put the box foot near the slope
  function automatic pair_word_t random_pair();
    pair_word_t   w;
    logic [127:0] raw;
    int           tx, ty, tw, th, bx, by, bw, bh, cx2, run, sel;
    raw = {$urandom, $urandom, $urandom, $urandom};
    w   = raw[$bits(pair_word_t)-1:0];
    sel = $urandom_range(0, 99);
    if (sel < 15) return w;

    sel = $urandom_range(0, 99);
    if (sel < 35)      w.kind = KIND_SOLID;
    else if (sel < 65) w.kind = KIND_RAMP_UP;
    else if (sel < 95) w.kind = KIND_RAMP_DOWN;
    else               w.kind = KIND_UNUSED;

    tw = pick_size(256);
    th = pick_size(256);
    bw = pick_size(64);
    bh = pick_size(64);
    tx = int'($urandom_range(0, 65535)) - 32768;
    ty = int'($urandom_range(0, 65535)) - 32768;
    // edges may just touch, which has to give no hit
    bx = tx - bw + int'($urandom_range(0, tw + bw));
    by = ty - bh + int'($urandom_range(0, th + bh));

    if ((w.kind == KIND_RAMP_UP || w.kind == KIND_RAMP_DOWN) &&
        $urandom_range(0, 3) != 0) begin
      cx2 = 2 * bx + bw;
      if (w.kind == KIND_RAMP_DOWN) cx2 = 4 * tx + 2 * tw - cx2;
      run = (cx2 - 2 * tx) / 2;
      // foot within a pixel or so of the slope, either side
      by = ty + th - bh - run + int'($urandom_range(0, 16)) - 8;
    end

    w.tile_x = COORD_BITS'(tx);
    w.tile_y = COORD_BITS'(ty);
    w.tile_w = SIZE_BITS'(tw);
    w.tile_h = SIZE_BITS'(th);
    w.box_x  = COORD_BITS'(bx);
    w.box_y  = COORD_BITS'(by);
    w.box_w  = SIZE_BITS'(bw);
    w.box_h  = SIZE_BITS'(bh);
    return w;
  endfunction

  task automatic run_phase(input int idle_pct, input int stall_mix, input int count);
    send_idle_pct = idle_pct;
    stall_pct     = stall_mix;
    repeat (count) begin
      while ($urandom_range(1, 100) <= send_idle_pct) idle_cycle();
      drive_word(random_pair());
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // --- directed: extremes ---
    // everything zero: empty rectangles never overlap
    send_pair(KIND_SOLID, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
    // largest coordinates and sizes, identical rectangles: y tie, far corner
    send_pair(KIND_SOLID, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 1'b1);
    // most negative corner through the unused kind (solid path)
    send_pair(KIND_UNUSED, -32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767, 1'b0);

    // --- directed: solid tile, each side ---
    send_pair(KIND_SOLID, 0, 0, 256, 256, -200, 50, 256, 100, 1'b0);  // from left
    send_pair(KIND_SOLID, 0, 0, 256, 256, 200, 50, 256, 100, 1'b1);   // from right
    send_pair(KIND_SOLID, 0, 0, 256, 256, 50, -200, 100, 256, 1'b0);  // from above
    send_pair(KIND_SOLID, 0, 0, 256, 256, 50, 200, 100, 256, 1'b1);   // from below
    send_pair(KIND_SOLID, 0, 0, 16, 16, 8, 8, 16, 16, 1'b0);          // equal overlaps
    send_pair(KIND_SOLID, 0, 0, 256, 256, 256, 0, 16, 16, 1'b0);      // touching in x
    send_pair(KIND_SOLID, 0, 0, 256, 256, 0, -16, 16, 16, 1'b1);      // touching in y
    send_pair(KIND_SOLID, 0, 0, 100, 100, 50, 50, 0, 0, 1'b0);        // zero-size box inside
    send_pair(KIND_UNUSED, 0, 0, 256, 256, 240, 0, 64, 256, 1'b0);    // unused kind, x axis

    // --- directed: ramps ---
    send_pair(KIND_RAMP_UP, 0, 0, 256, 256, 100, 200, 32, 100, 1'b1);    // grounded, sunk in
    send_pair(KIND_RAMP_UP, 0, 0, 256, 256, 100, 200, 32, 100, 1'b0);    // airborne, sunk in
    send_pair(KIND_RAMP_UP, 0, 0, 256, 256, 100, 0, 32, 32, 1'b0);       // airborne above: drop
    send_pair(KIND_RAMP_UP, 0, 0, 256, 256, 100, 0, 32, 32, 1'b1);       // grounded above: hit
    send_pair(KIND_RAMP_DOWN, 0, 0, 256, 256, 20, 100, 32, 100, 1'b0);   // mirrored x
    send_pair(KIND_RAMP_DOWN, 0, 0, 256, 256, 200, 0, 32, 16, 1'b0);     // down, above: drop
    send_pair(KIND_RAMP_UP, 0, 0, 256, 256, -16, 100, 32, 100, 1'b1);    // foot on left edge
    send_pair(KIND_RAMP_DOWN, 0, 0, 256, 256, 240, 100, 32, 100, 1'b1);  // foot on right edge
    send_pair(KIND_RAMP_UP, -256, -256, 256, 256, -101, -100, 1, 200, 1'b1);  // odd, negative
    send_pair(KIND_RAMP_DOWN, -256, -256, 256, 256, -160, -100, 1, 200, 1'b1); // odd mirror

    // sender holds off until every result is back
    idle_cycle();
    wait_drained();

    // --- random phases, different idling mixes ---
    run_phase(0, 0, PHASE_WORDS);
    idle_cycle();
    wait_drained();
    run_phase(50, 0, PHASE_WORDS);
    run_phase(0, 50, PHASE_WORDS);
    idle_cycle();
    wait_drained();
    run_phase(12, 12, PHASE_WORDS);

    idle_cycle();
    wait_drained();
    stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("tile_box_collision_test: done, clean");
    end else begin
      $display("tile_box_collision_test: done, errors");
    end
    $finish;
  end

endmodule
